// File: rtl/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// shared types, codes and default sizes for the partition fit allocator
// ----------------------------------------------------------------------------
package pfa_pkg;

  localparam int NUM_PARTITIONS_DEF = 16;
  localparam int SIZE_WIDTH_DEF     = 16;

  // fixed field widths of the ports
  localparam int IDX_PORT_W   = 4;
  localparam int AMOUNT_W     = 16;
  localparam int STATUS_W     = 2;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 5;
  localparam int POLICY_W     = 2;
  localparam int ACTIVE_W     = 5;

  // operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_ALLOC = 1'b1;

  // result status codes
  localparam logic [STATUS_W-1:0] STATUS_LOADED    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_ALLOCATED = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NO_FIT    = 2'd2;

  // fit policies, the unused code behaves as first fit
  localparam logic [POLICY_W-1:0] FIT_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] FIT_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] FIT_WORST = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE     = 2'd1;

  localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

endpackage

// File: rtl/partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// partition_fit_allocator
// fixed-partition allocator with first, best or worst fit over a size memory
// ----------------------------------------------------------------------------
//
// channel  direction  handshake              payload
// in_      input      in_valid / in_ready    in_operation, in_partition_index, in_amount
// out_     output     out_valid / out_ready  out_status, out_chosen_partition, out_leftover
// cfg_     input      cfg_valid / cfg_ready  cfg_index, cfg_wdata
//
// a load word goes from acceptance straight to the done state and its result;
// an allocate word reads limit = min(active_partitions, NUM_PARTITIONS) entries,
// one read per partition, then makes the last compare and moves from the scan
// state to the done state, which gives the result; the scan reads one size
// memory entry per cycle through a single subtract-and-compare unit
// reset (rst_n low, synchronous) clears the in-use marks, the control registers and
// the sequencer; partition sizes are undefined until loaded
// a word is accepted while a finished result still waits on out_; the
// sequencer then holds in its done state until the output register frees
//
module partition_fit_allocator #(
  parameter int NUM_PARTITIONS = pfa_pkg::NUM_PARTITIONS_DEF,
  parameter int SIZE_WIDTH     = pfa_pkg::SIZE_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [pfa_pkg::IDX_PORT_W-1:0]    in_partition_index,
  input  logic [pfa_pkg::AMOUNT_W-1:0]      in_amount,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [pfa_pkg::STATUS_W-1:0]      out_status,
  output logic [pfa_pkg::IDX_PORT_W-1:0]    out_chosen_partition,
  output logic [pfa_pkg::AMOUNT_W-1:0]      out_leftover,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [pfa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pfa_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  // memory address and scan counter widths
  localparam int IDX_W = (NUM_PARTITIONS > 1) ? $clog2(NUM_PARTITIONS) : 1;
  localparam int CNT_W = $clog2(NUM_PARTITIONS + 1);
  // wide enough for any port field and for size widths up to 48 bits
  localparam int EXT_W = 48;

  // configuration registers
  logic [pfa_pkg::POLICY_W-1:0] fit_policy_r, fit_policy_nxt;
  logic [pfa_pkg::ACTIVE_W-1:0] active_r, active_nxt;

  // sequencer and per-word control
  pfa_pkg::state_t              state_r, state_nxt;
  logic [CNT_W-1:0]             scan_r, scan_nxt;
  logic [CNT_W-1:0]             limit_r, limit_nxt;
  logic                         cmp_v_r, cmp_v_nxt;
  logic                         found_r, found_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [NUM_PARTITIONS-1:0]    in_use_r, in_use_nxt;

  // payload registers
  logic                         op_r, op_nxt;
  logic [SIZE_WIDTH-1:0]        amount_r, amount_nxt;
  logic [IDX_W-1:0]             pick_idx_r, pick_idx_nxt;
  logic [SIZE_WIDTH-1:0]        pick_left_r, pick_left_nxt;
  logic [pfa_pkg::STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [pfa_pkg::IDX_PORT_W-1:0] out_idx_r, out_idx_nxt;
  logic [pfa_pkg::AMOUNT_W-1:0] out_left_r, out_left_nxt;

  // size memory, one write port at load, one registered read port for the scan
  logic [SIZE_WIDTH-1:0]        size_mem [NUM_PARTITIONS];
  logic [SIZE_WIDTH-1:0]        rd_data_r;
  logic                         rd_used_r;
  logic [IDX_W-1:0]             rd_addr;
  logic [IDX_W-1:0]             cmp_idx_r;
  logic                         mem_we;
  logic [IDX_W-1:0]             ld_addr;
  logic [SIZE_WIDTH-1:0]        in_amount_trunc;

  // shared compare unit
  logic [SIZE_WIDTH:0]          diff;
  logic                         fits;
  logic                         take;
  logic                         issue;

  logic [EXT_W-1:0]             ld_idx_ext;
  logic [EXT_W-1:0]             amt_ext;
  logic [EXT_W-1:0]             pick_idx_ext;
  logic [EXT_W-1:0]             pick_left_ext;

  assign ld_idx_ext      = EXT_W'(in_partition_index);
  assign ld_addr         = ld_idx_ext[IDX_W-1:0];
  assign amt_ext         = EXT_W'(in_amount);
  // request kept to the stored size width
  assign in_amount_trunc = amt_ext[SIZE_WIDTH-1:0];
  assign pick_idx_ext    = EXT_W'(pick_idx_r);
  assign pick_left_ext   = EXT_W'(pick_left_r);

  assign rd_addr = scan_r[IDX_W-1:0];
  assign issue   = (state_r == pfa_pkg::ST_SCAN) && (scan_r < limit_r);

  // size minus request, borrow means too small
  assign diff = {1'b0, rd_data_r} - {1'b0, amount_r};
  assign fits = !diff[SIZE_WIDTH] && !rd_used_r;

  always_comb begin
    take = 1'b0;
    if (fits) begin
      if (!found_r) begin
        take = 1'b1;
      end else begin
        unique case (fit_policy_r)
          pfa_pkg::FIT_BEST:  take = diff[SIZE_WIDTH-1:0] < pick_left_r;
          pfa_pkg::FIT_WORST: take = diff[SIZE_WIDTH-1:0] > pick_left_r;
          default:            take = 1'b0;
        endcase
      end
    end
  end

  assign in_ready  = (state_r == pfa_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    fit_policy_nxt = fit_policy_r;
    active_nxt     = active_r;
    state_nxt      = state_r;
    scan_nxt       = scan_r;
    limit_nxt      = limit_r;
    cmp_v_nxt      = 1'b0;
    found_nxt      = found_r;
    out_valid_nxt  = out_valid_r;
    in_use_nxt     = in_use_r;
    op_nxt         = op_r;
    amount_nxt     = amount_r;
    pick_idx_nxt   = pick_idx_r;
    pick_left_nxt  = pick_left_r;
    out_status_nxt = out_status_r;
    out_idx_nxt    = out_idx_r;
    out_left_nxt   = out_left_r;
    mem_we         = 1'b0;

    if (cfg_valid) begin
      unique case (cfg_index)
        pfa_pkg::CFG_FIT_POLICY: fit_policy_nxt = cfg_wdata[pfa_pkg::POLICY_W-1:0];
        pfa_pkg::CFG_ACTIVE:     active_nxt     = cfg_wdata[pfa_pkg::ACTIVE_W-1:0];
        default: ;
      endcase
    end

    // result taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      pfa_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = in_operation;
          amount_nxt = in_amount_trunc;
          scan_nxt   = '0;
          found_nxt  = 1'b0;
          // active count saturates at the partition count
          if (32'(active_r) > NUM_PARTITIONS) begin
            limit_nxt = CNT_W'(NUM_PARTITIONS);
          end else begin
            limit_nxt = CNT_W'(active_r);
          end
          if (in_operation == pfa_pkg::OP_LOAD) begin
            // out-of-range load writes nothing but still answers
            if (32'(in_partition_index) < NUM_PARTITIONS) begin
              mem_we              = 1'b1;
              in_use_nxt[ld_addr] = 1'b0;
            end
            state_nxt = pfa_pkg::ST_DONE;
          end else begin
            state_nxt = pfa_pkg::ST_SCAN;
          end
        end
      end

      pfa_pkg::ST_SCAN: begin
        // read of entry scan_r is issued now, compared in the next cycle
        if (issue) begin
          scan_nxt  = scan_r + 1'b1;
          cmp_v_nxt = 1'b1;
        end
        if (cmp_v_r && take) begin
          found_nxt     = 1'b1;
          pick_idx_nxt  = cmp_idx_r;
          pick_left_nxt = diff[SIZE_WIDTH-1:0];
        end
        if (!issue && !cmp_v_r) begin
          state_nxt = pfa_pkg::ST_DONE;
        end
      end

      pfa_pkg::ST_DONE: begin
        // wait for a free output register
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = pfa_pkg::ST_IDLE;
          if (op_r == pfa_pkg::OP_LOAD) begin
            out_status_nxt = pfa_pkg::STATUS_LOADED;
            out_idx_nxt    = '0;
            out_left_nxt   = '0;
          end else if (found_r) begin
            out_status_nxt         = pfa_pkg::STATUS_ALLOCATED;
            out_idx_nxt            = pick_idx_ext[pfa_pkg::IDX_PORT_W-1:0];
            out_left_nxt           = pick_left_ext[pfa_pkg::AMOUNT_W-1:0];
            in_use_nxt[pick_idx_r] = 1'b1;
          end else begin
            // nothing fits, marks untouched
            out_status_nxt = pfa_pkg::STATUS_NO_FIT;
            out_idx_nxt    = '0;
            out_left_nxt   = '0;
          end
        end
      end

      default: begin
        state_nxt = pfa_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fit_policy_r <= pfa_pkg::FIT_FIRST;
      active_r     <= pfa_pkg::ACTIVE_RESET;
      state_r      <= pfa_pkg::ST_IDLE;
      scan_r       <= '0;
      limit_r      <= '0;
      cmp_v_r      <= 1'b0;
      found_r      <= 1'b0;
      out_valid_r  <= 1'b0;
      in_use_r     <= '0;
    end else begin
      fit_policy_r <= fit_policy_nxt;
      active_r     <= active_nxt;
      state_r      <= state_nxt;
      scan_r       <= scan_nxt;
      limit_r      <= limit_nxt;
      cmp_v_r      <= cmp_v_nxt;
      found_r      <= found_nxt;
      out_valid_r  <= out_valid_nxt;
      in_use_r     <= in_use_nxt;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    op_r         <= op_nxt;
    amount_r     <= amount_nxt;
    pick_idx_r   <= pick_idx_nxt;
    pick_left_r  <= pick_left_nxt;
    out_status_r <= out_status_nxt;
    out_idx_r    <= out_idx_nxt;
    out_left_r   <= out_left_nxt;
  end

  // size memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      size_mem[ld_addr] <= in_amount_trunc;
    end
    rd_data_r <= size_mem[rd_addr];
    rd_used_r <= in_use_r[rd_addr];
    cmp_idx_r <= rd_addr;
  end

  assign out_valid            = out_valid_r;
  assign out_status           = out_status_r;
  assign out_chosen_partition = out_idx_r;
  assign out_leftover         = out_left_r;

endmodule
